>>> rtl/segmented_image_loader_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the segmented image loader checks
// ---------------------------------------------------------------------------
`ifndef SEGMENTED_IMAGE_LOADER_MACROS_SVH
`define SEGMENTED_IMAGE_LOADER_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define SIL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segmented_image_loader: check failed");

// Next-cycle implication, disabled while reset is held
`define SIL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segmented_image_loader: check failed");

`endif

>>> rtl/sil_pkg.sv
// ---------------------------------------------------------------------------
// sil_pkg
// Types and constants shared by the segmented image loader files.
// ---------------------------------------------------------------------------
package sil_pkg;

    typedef enum logic [2:0] {
        PH_HDR_HI   = 3'd0,
        PH_HDR_LO   = 3'd1,
        PH_HDR_LEN  = 3'd2,
        PH_DATA     = 3'd3,
        PH_EXEC_HI  = 3'd4,
        PH_EXEC_LO  = 3'd5,
        PH_WAIT_EOF = 3'd6,
        PH_HALTED   = 3'd7
    } t_phase;

    // result kinds
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_FAIL   = 2'd2;

    // write targets (extended bank writes keep the same address)
    localparam logic [1:0] TGT_MAIN    = 2'd0;
    localparam logic [1:0] TGT_MIRROR  = 2'd1;
    localparam logic [1:0] TGT_EXT     = 2'd2;

    // failure causes
    localparam logic [1:0] CAUSE_NONE      = 2'd0;
    localparam logic [1:0] CAUSE_TRUNCATED = 2'd1;
    localparam logic [1:0] CAUSE_PAGE      = 2'd2;
    localparam logic [1:0] CAUSE_TRAILING  = 2'd3;

    localparam logic [15:0] MIRROR_OFS  = 16'h8000;
    localparam logic [6:0]  PAGE_END_HI = 7'h7f;    // low byte 0xfe or 0xff
    localparam logic [1:0]  MASK_ALL    = 2'b11;

endpackage

>>> rtl/sil_if.sv
// ---------------------------------------------------------------------------
// sil_in_if / sil_out_if
// Valid/ready channels for image bytes in and loader results out.
// ---------------------------------------------------------------------------
interface sil_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_file;

    modport source (output valid, output byte_value, output end_of_file, input ready);
    modport sink   (input valid, input byte_value, input end_of_file, output ready);
endinterface

interface sil_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [1:0]  write_target;
    logic [15:0] exec_address;
    logic [1:0]  channel_mask;
    logic [1:0]  fail_cause;

    modport source (output valid, output result_kind, output write_address,
                    output write_data, output write_target, output exec_address,
                    output channel_mask, output fail_cause, input ready);
    modport sink   (input valid, input result_kind, input write_address,
                    input write_data, input write_target, input exec_address,
                    input channel_mask, input fail_cause, output ready);
endinterface

>>> rtl/segmented_image_loader.sv
// ---------------------------------------------------------------------------
// segmented_image_loader
// Parses a segmented program image byte by byte into memory write requests.
// ---------------------------------------------------------------------------
// Usage:
//   i_req carries one image byte per request, or an end-of-file marker.
//   o_res carries at most one result per input request: a memory write for
//   each data byte, a finish result with the exec address, or a failure with
//   its cause. Header bytes, save a page-crossing length byte (a failure), and
//   exec address bytes give no result. A result appears on o_res in the cycle
//   after its input request. Throughput: one input request per cycle unless
//   o_res stalls; the parse state and the output register are the only stages,
//   so every byte takes one pass through them. i_req.ready is high while the
//   output register is empty or being drained in the same cycle; when the
//   receiver stalls with a result pending, input is held off until that
//   result is taken. Reset (synchronous, active low) returns to expecting a
//   header byte with the channel mask at 3 and the output register empty.
//   After a finish or failure result the loader ignores further input
//   (still accepted, no results) until the next reset.
// ---------------------------------------------------------------------------
module segmented_image_loader
    import sil_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    sil_in_if.sink           i_req,
    sil_out_if.source        o_res
);

    t_phase      r_phase,   n_phase;
    logic [15:0] r_addr,    n_addr;
    logic [8:0]  r_left,    n_left;
    logic        r_seen,    n_seen;
    logic [7:0]  r_high,    n_high;
    logic [1:0]  r_mask,    n_mask;

    logic        r_valid;
    logic [1:0]  r_kind,    n_kind;
    logic [15:0] r_waddr,   n_waddr;
    logic [7:0]  r_wdata,   n_wdata;
    logic [1:0]  r_target,  n_target;
    logic [15:0] r_exec,    n_exec;
    logic [1:0]  r_cmask,   n_cmask;
    logic [1:0]  r_cause,   n_cause;
    logic        n_emit;

    logic        accept;
    logic [7:0]  b;
    logic [8:0]  seg_len;
    logic [8:0]  last_lo;
    logic [8:0]  left_dec;

    assign i_req.ready = !r_valid || o_res.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign b           = i_req.byte_value;

    // length byte 0 means a full page
    assign seg_len  = (b == 8'd0) ? 9'd256 : {1'b0, b};
    assign last_lo  = {1'b0, r_addr[7:0]} + seg_len - 9'd1;
    assign left_dec = r_left - 9'd1;

    always_comb begin
        n_phase  = r_phase;
        n_addr   = r_addr;
        n_left   = r_left;
        n_seen   = r_seen;
        n_high   = r_high;
        n_mask   = r_mask;
        n_emit   = 1'b0;
        n_kind   = KIND_WRITE;
        n_waddr  = '0;
        n_wdata  = '0;
        n_target = TGT_MAIN;
        n_exec   = '0;
        n_cmask  = r_mask;
        n_cause  = CAUSE_NONE;

        if (accept && r_phase != PH_HALTED) begin
            if (i_req.end_of_file) begin
                n_phase = PH_HALTED;
                n_emit  = 1'b1;
                if (r_phase == PH_WAIT_EOF) begin
                    n_kind = KIND_FINISH;
                    n_exec = r_addr;
                end else begin
                    n_kind  = KIND_FAIL;
                    n_cause = CAUSE_TRUNCATED;
                    n_mask  = MASK_ALL;
                    n_cmask = MASK_ALL;
                end
            end else begin
                unique case (r_phase)
                    PH_HDR_HI: begin
                        if (b == 8'd0 && r_seen) begin
                            n_phase = PH_EXEC_HI;
                        end else begin
                            n_high  = b;
                            n_phase = PH_HDR_LO;
                        end
                    end
                    PH_HDR_LO: begin
                        n_addr  = {r_high, b};
                        n_phase = PH_HDR_LEN;
                    end
                    PH_HDR_LEN: begin
                        if (last_lo[8]) begin
                            n_phase = PH_HALTED;
                            n_emit  = 1'b1;
                            n_kind  = KIND_FAIL;
                            n_cause = CAUSE_PAGE;
                            n_mask  = MASK_ALL;
                            n_cmask = MASK_ALL;
                        end else begin
                            // segment ending at xFE/xFF of pages 1..4 trims the mask
                            if (last_lo[7:1] == PAGE_END_HI
                                    && r_high >= 8'd1 && r_high <= 8'd4) begin
                                n_mask = (r_high >= 8'd2) ? (r_mask & 2'b10) : 2'b00;
                            end
                            n_left  = seg_len;
                            n_seen  = 1'b1;
                            n_phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        n_emit  = 1'b1;
                        n_kind  = KIND_WRITE;
                        n_wdata = b;
                        if (r_addr[15]) begin
                            n_target = TGT_EXT;
                            n_waddr  = r_addr;
                        end else if (r_addr[15:8] == 8'd0) begin
                            n_target = TGT_MIRROR;
                            n_waddr  = r_addr + MIRROR_OFS;
                        end else begin
                            n_target = TGT_MAIN;
                            n_waddr  = r_addr;
                        end
                        n_addr = r_addr + 16'd1;
                        n_left = left_dec;
                        if (left_dec == 9'd0) begin
                            n_phase = PH_HDR_HI;
                        end
                    end
                    PH_EXEC_HI: begin
                        n_high  = b;
                        n_phase = PH_EXEC_LO;
                    end
                    PH_EXEC_LO: begin
                        n_addr  = {r_high, b};
                        n_phase = PH_WAIT_EOF;
                    end
                    PH_WAIT_EOF: begin
                        n_phase = PH_HALTED;
                        n_emit  = 1'b1;
                        n_kind  = KIND_FAIL;
                        n_cause = CAUSE_TRAILING;
                        n_mask  = MASK_ALL;
                        n_cmask = MASK_ALL;
                    end
                    PH_HALTED: begin
                        n_phase = PH_HALTED;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR_HI;
            r_addr  <= '0;
            r_left  <= '0;
            r_seen  <= 1'b0;
            r_high  <= '0;
            r_mask  <= MASK_ALL;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_addr  <= n_addr;
            r_left  <= n_left;
            r_seen  <= n_seen;
            r_high  <= n_high;
            r_mask  <= n_mask;
            if (n_emit) begin
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_emit) begin
            r_kind   <= n_kind;
            r_waddr  <= n_waddr;
            r_wdata  <= n_wdata;
            r_target <= n_target;
            r_exec   <= n_exec;
            r_cmask  <= n_cmask;
            r_cause  <= n_cause;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.result_kind   = r_kind;
    assign o_res.write_address = r_waddr;
    assign o_res.write_data    = r_wdata;
    assign o_res.write_target  = r_target;
    assign o_res.exec_address  = r_exec;
    assign o_res.channel_mask  = r_cmask;
    assign o_res.fail_cause    = r_cause;

endmodule

>>> rtl/sil_checker.sv
// ---------------------------------------------------------------------------
// sil_checker
// Port-level checks for the segmented image loader, bound to the top level.
// ---------------------------------------------------------------------------
`include "segmented_image_loader_macros.svh"

module sil_checker
    import sil_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_kind,
    input logic [15:0] i_waddr,
    input logic [1:0]  i_target,
    input logic [1:0]  i_cmask,
    input logic [1:0]  i_cause
);

    // pending result holds until taken
    `SIL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // a new result only follows an accepted input request
    `SIL_ASSERT_NOW(a_out_cause, i_clk, i_rst_n, i_out_valid && !$past(i_out_valid),
        $past(i_in_valid && i_in_ready))

    // finish or failure halts the loader: nothing follows once it is taken
    `SIL_ASSERT_NEXT(a_halt_quiet, i_clk, i_rst_n,
        i_out_valid && i_out_ready && (i_kind == KIND_FINISH || i_kind == KIND_FAIL),
        !i_out_valid)

    // failure carries a cause and a full mask; other results carry no cause
    `SIL_ASSERT_NOW(a_fail_fields, i_clk, i_rst_n, i_out_valid,
        (i_kind == KIND_FAIL) == (i_cause != CAUSE_NONE)
        && (i_kind != KIND_FAIL || i_cmask == MASK_ALL))

    // mirror writes land in page 0x80, extended bank writes in the upper half
    `SIL_ASSERT_NOW(a_target_map, i_clk, i_rst_n, i_out_valid && i_kind == KIND_WRITE,
        (i_target != TGT_MIRROR || i_waddr[15:8] == 8'h80)
        && (i_target != TGT_EXT || i_waddr[15]))

endmodule

bind segmented_image_loader sil_checker u_sil_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_kind      (o_res.result_kind),
    .i_waddr     (o_res.write_address),
    .i_target    (o_res.write_target),
    .i_cmask     (o_res.channel_mask),
    .i_cause     (o_res.fail_cause)
);
